// ===== rtl/core/tpid_pkg.sv =====
// tpid_pkg: shared types, register indexes and reset values for the
// threshold pulse interval detector core; no dependencies

package tpid_pkg;

	localparam int CHANNELS_DEF    = 3;
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int THR_W           = 12;
	localparam int TIME_W          = 32;
	localparam int CLASS_W         = 2;
	localparam int APB_AW          = 5;
	localparam int APB_DW          = 32;

	typedef enum logic [2:0] {
		REG_START_THR   = 3'd0,
		REG_CLASS_TWO   = 3'd1,
		REG_CLASS_THREE = 3'd2,
		REG_MAX_DUR     = 3'd3,
		REG_GAP_LIMIT   = 3'd4
	} reg_idx_t;

	localparam logic [THR_W-1:0]  START_THR_RST   = 12'd1000;
	localparam logic [THR_W-1:0]  CLASS_TWO_RST   = 12'd2000;
	localparam logic [THR_W-1:0]  CLASS_THREE_RST = 12'd3000;
	localparam logic [TIME_W-1:0] MAX_DUR_RST     = 32'd1000000;
	localparam logic [TIME_W-1:0] GAP_LIMIT_RST   = 32'd100;

	localparam logic [CLASS_W-1:0] CLASS_LOW  = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_MID  = 2'd2;
	localparam logic [CLASS_W-1:0] CLASS_HIGH = 2'd3;

	typedef struct packed {
		logic [THR_W-1:0]  start_thr;
		logic [THR_W-1:0]  class_two_thr;
		logic [THR_W-1:0]  class_three_thr;
		logic [TIME_W-1:0] max_dur;
		logic [TIME_W-1:0] gap_limit;
	} tpid_cfg_t;

endpackage

// ===== rtl/core/tpid_cfg_regs.sv =====
// tpid_cfg_regs: apb register file holding thresholds and time limits
// depends on tpid_pkg

module tpid_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tpid_pkg::APB_AW-1:0] paddr,
	input  logic [tpid_pkg::APB_DW-1:0] pwdata,
	output logic [tpid_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	output tpid_pkg::tpid_cfg_t         cfg
);

	tpid_pkg::tpid_cfg_t cfg_q;
	logic                wr_en;
	logic [2:0]          reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_thr       <= tpid_pkg::START_THR_RST;
			cfg_q.class_two_thr   <= tpid_pkg::CLASS_TWO_RST;
			cfg_q.class_three_thr <= tpid_pkg::CLASS_THREE_RST;
			cfg_q.max_dur         <= tpid_pkg::MAX_DUR_RST;
			cfg_q.gap_limit       <= tpid_pkg::GAP_LIMIT_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				tpid_pkg::REG_START_THR: begin
					cfg_q.start_thr <= pwdata[tpid_pkg::THR_W-1:0];
				end
				tpid_pkg::REG_CLASS_TWO: begin
					cfg_q.class_two_thr <= pwdata[tpid_pkg::THR_W-1:0];
				end
				tpid_pkg::REG_CLASS_THREE: begin
					cfg_q.class_three_thr <= pwdata[tpid_pkg::THR_W-1:0];
				end
				tpid_pkg::REG_MAX_DUR: begin
					cfg_q.max_dur <= pwdata[tpid_pkg::TIME_W-1:0];
				end
				tpid_pkg::REG_GAP_LIMIT: begin
					cfg_q.gap_limit <= pwdata[tpid_pkg::TIME_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			tpid_pkg::REG_START_THR:   prdata = tpid_pkg::APB_DW'(cfg_q.start_thr);
			tpid_pkg::REG_CLASS_TWO:   prdata = tpid_pkg::APB_DW'(cfg_q.class_two_thr);
			tpid_pkg::REG_CLASS_THREE: prdata = tpid_pkg::APB_DW'(cfg_q.class_three_thr);
			tpid_pkg::REG_MAX_DUR:     prdata = tpid_pkg::APB_DW'(cfg_q.max_dur);
			tpid_pkg::REG_GAP_LIMIT:   prdata = tpid_pkg::APB_DW'(cfg_q.gap_limit);
			default:                   prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/tpid_detect.sv =====
// tpid_detect: per-channel interval state and a combinational update that
// closes, splits or opens intervals; depends on tpid_pkg

module tpid_detect #(
	parameter int CHANNELS    = tpid_pkg::CHANNELS_DEF,
	parameter int SAMPLE_BITS = tpid_pkg::SAMPLE_BITS_DEF,
	parameter int CH_W        = $clog2(CHANNELS + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tpid_pkg::tpid_cfg_t            cfg,
	input  logic                           take,
	input  logic [CH_W-1:0]                channel,
	input  logic [SAMPLE_BITS-1:0]         sample,
	input  logic [tpid_pkg::TIME_W-1:0]    time_us,
	output logic                           res_valid,
	output logic [CH_W-1:0]                res_channel_number,
	output logic [tpid_pkg::CLASS_W-1:0]   res_level_class,
	output logic [tpid_pkg::TIME_W-1:0]    res_first_us,
	output logic [tpid_pkg::TIME_W-1:0]    res_duration_us,
	output logic [SAMPLE_BITS-1:0]         res_peak
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CMP_W = (SAMPLE_BITS > tpid_pkg::THR_W) ? SAMPLE_BITS : tpid_pkg::THR_W;
	localparam int TW    = tpid_pkg::TIME_W;

	logic                   in_iv_q  [CHANNELS];
	logic                   seen_q   [CHANNELS];
	logic [TW-1:0]          start_q  [CHANNELS];
	logic [SAMPLE_BITS-1:0] peak_q   [CHANNELS];
	logic [TW-1:0]          last_q   [CHANNELS];

	logic                   ch_ok;
	logic [IDX_W-1:0]       idx;
	logic [TW-1:0]          gap;
	logic                   gap_clear;
	logic                   eff_in;
	logic                   above;
	logic [SAMPLE_BITS-1:0] pk_max;
	logic [TW-1:0]          diff;
	logic                   split;
	logic                   close_iv;
	logic [TW-1:0]          end_us;
	logic [SAMPLE_BITS-1:0] emit_pk;
	logic                   nxt_in;
	logic [TW-1:0]          nxt_start;
	logic [SAMPLE_BITS-1:0] nxt_peak;
	logic                   upd;

	assign ch_ok = channel < CH_W'(CHANNELS);
	assign idx   = channel[IDX_W-1:0];
	assign upd   = take & ch_ok;

	assign gap       = time_us - last_q[idx] - TW'(1);
	assign gap_clear = seen_q[idx] & (gap > cfg.gap_limit);
	assign eff_in    = in_iv_q[idx] & ~gap_clear;

	assign above  = CMP_W'(sample) > CMP_W'(cfg.start_thr);
	assign pk_max = (sample > peak_q[idx]) ? sample : peak_q[idx];
	assign diff   = time_us - start_q[idx];

	assign split    = above & eff_in & (diff >= cfg.max_dur);
	assign close_iv = ~above & eff_in;
	assign end_us   = split ? time_us : (time_us - TW'(1));
	assign emit_pk  = split ? pk_max : peak_q[idx];

	always_comb begin
		nxt_in    = eff_in;
		nxt_start = start_q[idx];
		nxt_peak  = peak_q[idx];
		if (above) begin
			nxt_in = 1'b1;
			if (!eff_in) begin
				nxt_start = time_us;
				nxt_peak  = sample;
			end else if (split) begin
				nxt_start = time_us + TW'(1);
				nxt_peak  = sample;
			end else begin
				nxt_peak = pk_max;
			end
		end else begin
			nxt_in = 1'b0;
		end
	end

	assign res_valid          = upd & (split | close_iv) & (end_us >= start_q[idx]);
	assign res_channel_number = channel + CH_W'(1);
	assign res_first_us       = start_q[idx];
	assign res_duration_us    = diff + TW'(split);
	assign res_peak           = emit_pk;

	always_comb begin
		priority if (CMP_W'(emit_pk) < CMP_W'(cfg.class_two_thr)) begin
			res_level_class = tpid_pkg::CLASS_LOW;
		end else if (CMP_W'(emit_pk) < CMP_W'(cfg.class_three_thr)) begin
			res_level_class = tpid_pkg::CLASS_MID;
		end else begin
			res_level_class = tpid_pkg::CLASS_HIGH;
		end
	end

	for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
		logic wr;
		assign wr = upd & (idx == IDX_W'(c));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				in_iv_q[c] <= 1'b0;
				seen_q[c]  <= 1'b0;
			end else if (wr) begin
				in_iv_q[c] <= nxt_in;
				seen_q[c]  <= 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (wr) begin
				start_q[c] <= nxt_start;
				peak_q[c]  <= nxt_peak;
				last_q[c]  <= time_us;
			end
		end
	end

endmodule

// ===== rtl/core/threshold_pulse_interval_detector_core.sv =====
// threshold_pulse_interval_detector_core: top level with input register,
// result register and handshake; uses tpid_pkg, tpid_cfg_regs, tpid_detect
//
//   group   dir  fields (tdata, low bit first)
//   s_axis  in   channel, sample, time_us
//   m_axis  out  channel_number, level_class, first_us, duration_us, peak
//   apb     cfg  start_threshold, class_two_threshold, class_three_threshold,
//                split_length_us, gap_limit_us at byte addresses 0..16
//
// one word per cycle sustained while m_axis is not stalled; a word lands in
// the input register, is evaluated there against its channel's state and,
// if it closes or splits an interval, gives a result that is registered and
// shown on m_axis; channel state is flip-flops updated when the word is
// taken, so words of the same channel may follow each other directly
// a stalled m_axis holds its word and the input register; reset clears each
// channel's interval and seen flags and loads the register defaults

module threshold_pulse_interval_detector_core #(
	parameter int CHANNELS    = tpid_pkg::CHANNELS_DEF,
	parameter int SAMPLE_BITS = tpid_pkg::SAMPLE_BITS_DEF,
	parameter int CH_W        = $clog2(CHANNELS + 1),
	parameter int IN_W        = ((CH_W + SAMPLE_BITS + tpid_pkg::TIME_W + 7) / 8) * 8,
	parameter int OUT_W       = ((CH_W + tpid_pkg::CLASS_W + 2 * tpid_pkg::TIME_W
	                              + SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [IN_W-1:0]             s_tdata,   // channel, sample, time_us
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [OUT_W-1:0]            m_tdata,   // channel_number, level_class,
	                                               // first_us, duration_us, peak
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tpid_pkg::APB_AW-1:0] paddr,
	input  logic [tpid_pkg::APB_DW-1:0] pwdata,
	output logic [tpid_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);

	localparam int TW = tpid_pkg::TIME_W;

	tpid_pkg::tpid_cfg_t cfg;

	logic                          valid_s1;
	logic [CH_W-1:0]               channel_s1;
	logic [SAMPLE_BITS-1:0]        sample_s1;
	logic [TW-1:0]                 time_s1;
	logic                          out_free;
	logic                          take;

	logic                          res_valid;
	logic [CH_W-1:0]               res_channel_number;
	logic [tpid_pkg::CLASS_W-1:0]  res_level_class;
	logic [TW-1:0]                 res_first_us;
	logic [TW-1:0]                 res_duration_us;
	logic [SAMPLE_BITS-1:0]        res_peak;

	logic                          out_valid_q;
	logic [CH_W-1:0]               out_channel_number_q;
	logic [tpid_pkg::CLASS_W-1:0]  out_level_class_q;
	logic [TW-1:0]                 out_first_us_q;
	logic [TW-1:0]                 out_duration_us_q;
	logic [SAMPLE_BITS-1:0]        out_peak_q;

	tpid_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign out_free = ~out_valid_q | m_tready;
	assign take     = valid_s1 & out_free;
	assign s_tready = ~valid_s1 | out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			channel_s1 <= s_tdata[CH_W-1:0];
			sample_s1  <= s_tdata[CH_W+SAMPLE_BITS-1:CH_W];
			time_s1    <= s_tdata[CH_W+SAMPLE_BITS+TW-1:CH_W+SAMPLE_BITS];
		end
	end

	tpid_detect #(
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.CH_W        (CH_W)
	) u_detect (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg),
		.take               (take),
		.channel            (channel_s1),
		.sample             (sample_s1),
		.time_us            (time_s1),
		.res_valid          (res_valid),
		.res_channel_number (res_channel_number),
		.res_level_class    (res_level_class),
		.res_first_us       (res_first_us),
		.res_duration_us    (res_duration_us),
		.res_peak           (res_peak)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= take & res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_valid) begin
			out_channel_number_q <= res_channel_number;
			out_level_class_q    <= res_level_class;
			out_first_us_q       <= res_first_us;
			out_duration_us_q    <= res_duration_us;
			out_peak_q           <= res_peak;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({out_peak_q, out_duration_us_q, out_first_us_q,
	                          out_level_class_q, out_channel_number_q});

endmodule
